@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry and control types for the sorted descending priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    typedef struct packed {
        logic signed [31:0] cost;
        logic        [15:0] period;
        logic        [15:0] plant;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t item;
    } cell_ctrl_t;

endpackage

@@ src/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with the broadcast insert key and shifts
// towards the tail on insert or towards the head on pop.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               valid,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               keep
);
    import spq_pkg::*;

    entry_t entry_reg, entry_next;

    assign keep  = valid && ($signed(entry_reg.cost) > $signed(ctrl.item.cost));
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (!keep) begin
                entry_next = left_keep ? ctrl.item : left_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/sorted_descending_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted descending priority queue
// A row of cells keeps up to DEPTH entries sorted by descending signed cost.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_func selects insert or pop, and an
// insert carries a Q16.16 cost with period and plant tags. Every request
// gives exactly one result on the m_ channel.
// An insert places its entry ahead of every entry with a smaller or equal
// cost; an insert into a full queue is dropped and flagged by dropped_full.
// A pop returns the head entry; a pop from an empty queue sets was_empty.
// m_occupancy reports the number of entries held after the request.
// Accepted requests are registered into the result register. One request
// is taken every cycle while the receiver does not stall: each cell performs
// a single compare against the broadcast key and a single shift, all cells
// in parallel. When the receiver stalls, the result register holds and
// s_ready falls until the result is taken.
// Reset (aresetn low, synchronous) empties the queue and the result register.
// ----------------------------------------------------------------------------
module sorted_descending_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [31:0] s_cost,
    input  logic        [15:0] s_period,
    input  logic        [15:0] s_plant,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_head_valid,
    output logic signed [31:0] m_head_cost,
    output logic        [15:0] m_head_period,
    output logic        [15:0] m_head_plant,
    output logic               m_dropped_full,
    output logic               m_was_empty,
    output logic        [4:0]  m_occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    entry_t           head_reg, head_next;
    logic             head_valid_reg, head_valid_next;
    logic             dropped_reg, dropped_next;
    logic             empty_flag_reg, empty_flag_next;
    logic [4:0]       occ_reg, occ_next;

    logic             accept, is_pop, full, empty;
    logic [CNT_W+4:0] count_ext;
    cell_ctrl_t       ctrl;
    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_keep;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_pop  = (s_func == FUNC_POP);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.ins       = accept && !is_pop && !full;
    assign ctrl.pop       = accept && is_pop && !empty;
    assign ctrl.item.cost   = s_cost;
    assign ctrl.item.period = s_period;
    assign ctrl.item.plant  = s_plant;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic   left_keep;
        entry_t left_entry, right_entry;

        if (i == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_entry = ctrl.item;
        end else begin : g_inner
            assign left_keep  = cell_keep[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .valid       (count_reg > CNT_W'(i)),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = {5'b0, count_next};

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        dropped_next    = dropped_reg;
        empty_flag_next = empty_flag_reg;
        occ_next        = occ_reg;
        if (accept) begin
            m_valid_next    = 1'b1;
            head_valid_next = ctrl.pop;
            head_next       = ctrl.pop ? cell_entry[0] : '0;
            dropped_next    = !is_pop && full;
            empty_flag_next = is_pop && empty;
            occ_next        = count_ext[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg       <= head_next;
        head_valid_reg <= head_valid_next;
        dropped_reg    <= dropped_next;
        empty_flag_reg <= empty_flag_next;
        occ_reg        <= occ_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_head_valid   = head_valid_reg;
    assign m_head_cost    = head_reg.cost;
    assign m_head_period  = head_reg.period;
    assign m_head_plant   = head_reg.plant;
    assign m_dropped_full = dropped_reg;
    assign m_was_empty    = empty_flag_reg;
    assign m_occupancy    = occ_reg;

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Request accepted while a result was stalled.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("Insert did not increase the entry count.");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(2) |-> $signed(cell_entry[0].cost) >= $signed(cell_entry[1].cost))
        else $error("Head entry is not the largest cost.");

endmodule
